>>> rtl/ais_bf_pkg.sv
package ais_bf_pkg;

    localparam int MAX_SYMBOLS_DEF = 256;
    localparam int SYM_BITS        = 6;
    localparam int MAX_TEXT_CHARS  = 64;
    localparam int VALUE_W         = 32;

    // De-armouring: code minus the base, less the gap when above the limit
    localparam logic [7:0] ARMOR_BASE  = 8'd48;
    localparam logic [7:0] ARMOR_LIMIT = 8'd40;
    localparam logic [7:0] ARMOR_GAP   = 8'd8;

    // Divide by six: multiply by the reciprocal and shift, exact below 8192
    localparam int DIV6_MUL = 2731;
    localparam int DIV6_SH  = 14;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_NUM  = 2'd1,
        OP_TEXT = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_LONG  = 2'd2,
        ST_SPARE = 2'd3
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  acc;
        logic [SYM_BITS-1:0] sym;
        logic [2:0]          off;
        logic [8:0]          rem;
        logic                fill;
    } bfu_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [2:0]         take;
        logic [2:0]         off;
        logic               adv;
    } bfu_rsp_t;

    function automatic logic [8:0] div6(input logic [10:0] v);
        logic [22:0] prod;
        prod = 23'(v) * 23'(DIV6_MUL);
        return prod[22:DIV6_SH];
    endfunction

endpackage

>>> rtl/ais_payload_bitfield_reader.sv
// Load request: taken while busy is low; a closing load shows its status in the next cycle.
// Numeric read: set-up, then the shift state walks each stored symbol the field touches;
//   zero-length and out-of-range reads end after set-up.
// Text read: set-up, then a check and shifts per character (just the check after the text ends).
// Reset clears the sequencer, symbol count, overflow flag and result strobe, not the store.
// One request at a time; results cannot be stalled by the receiver.
module ais_payload_bitfield_reader #(
    parameter int MAX_SYMBOLS = ais_bf_pkg::MAX_SYMBOLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [7:0]         char_code,
    input  logic               first_char,
    input  logic               last_char,
    input  logic [10:0]        bit_start,
    input  logic [8:0]         bit_count,
    input  logic               want_signed,
    output logic               result_valid,
    output logic signed [31:0] field_value,
    output logic [6:0]         text_char,
    output logic [1:0]         status,
    output logic               last
);
    import ais_bf_pkg::*;

    // Widths: symbol count, store address, symbol index, payload bit positions
    localparam int CW = $clog2(MAX_SYMBOLS + 1);
    localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int IW = (CW > 9) ? CW : 9;
    localparam int PW = $clog2(MAX_SYMBOLS * SYM_BITS + 1);
    localparam int EW = (PW > 12) ? PW : 12;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PREP  = 4'b0010,
        S_CHAR  = 4'b0100,
        S_SHIFT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Request held for the length of a read
    logic               text_reg, text_next;
    logic               sgn_reg, sgn_next;
    logic [10:0]        start_reg, start_next;
    logic [8:0]         len_reg, len_next;

    // Walk position and accumulator
    logic [IW-1:0]      idx_reg, idx_next;
    logic [2:0]         off_reg, off_next;
    logic [8:0]         rem_reg, rem_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               fill_reg, fill_next;

    // Text bookkeeping
    logic [6:0]         left_reg, left_next;
    logic [EW-1:0]      cur_end_reg, cur_end_next;
    logic               ended_reg, ended_next;
    logic               tst_reg, tst_next;

    // Payload state
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;

    // Result registers
    logic               valid_reg, valid_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [6:0]         char_reg, char_next;
    logic [1:0]         status_reg, status_next;
    logic               last_reg, last_next;

    // Store ports
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [SYM_BITS-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [SYM_BITS-1:0] rd_data;

    bfu_req_t           unit_req;
    bfu_rsp_t           unit_rsp;

    // Set-up arithmetic
    logic [8:0]         q_start;
    logic [2:0]         r_start;
    logic [8:0]         q_len;
    logic [2:0]         r_len;
    logic [IW-1:0]      idx_first;
    logic [EW-1:0]      bits_total;
    logic [EW-1:0]      num_end;
    logic [EW-1:0]      text_end;
    logic [6:0]         n_chars;

    // Shift-step results
    logic [8:0]         rem_step;
    logic [IW-1:0]      idx_step;
    logic               accept;
    logic [7:0]         armor_sub;
    logic [7:0]         sym_byte;

    ais_bf_store #(
        .DEPTH(MAX_SYMBOLS),
        .AW   (AW)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    ais_bf_unit u_unit (
        .req(unit_req),
        .rsp(unit_rsp)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Start and length split into symbol index and bit offset
    assign q_start   = div6(start_reg);
    assign r_start   = 3'(start_reg - 11'({q_start, 2'b00}) - 11'({q_start, 1'b0}));
    assign q_len     = div6({2'b00, len_reg});
    assign r_len     = 3'(len_reg - 9'({q_len, 2'b00}) - 9'({q_len, 1'b0}));
    assign idx_first = IW'(q_start);
    assign n_chars   = (q_len > 9'(MAX_TEXT_CHARS)) ? 7'(MAX_TEXT_CHARS) : q_len[6:0];

    // Payload length in bits is six times the symbol count
    assign bits_total = EW'({count_reg, 2'b00}) + EW'({count_reg, 1'b0});
    assign num_end    = EW'(start_reg) + EW'(len_reg);
    assign text_end   = EW'(start_reg) + EW'(len_reg) - EW'(r_len);

    // De-armour: code minus the base, less the gap above the limit
    assign armor_sub = (char_code > (ARMOR_BASE + ARMOR_LIMIT)) ? ARMOR_GAP : 8'd0;
    assign sym_byte  = char_code - ARMOR_BASE - armor_sub;

    assign unit_req.acc  = acc_reg;
    assign unit_req.sym  = rd_data;
    assign unit_req.off  = off_reg;
    assign unit_req.rem  = rem_reg;
    assign unit_req.fill = fill_reg;

    assign rem_step = rem_reg - 9'(unit_rsp.take);
    assign idx_step = idx_reg + IW'(unit_rsp.adv);

    always_comb
    begin
        logic [CW-1:0] c0;
        logic          o0;

        state_next   = state_reg;
        text_next    = text_reg;
        sgn_next     = sgn_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        off_next     = off_reg;
        rem_next     = rem_reg;
        acc_next     = acc_reg;
        fill_next    = fill_reg;
        left_next    = left_reg;
        cur_end_next = cur_end_reg;
        ended_next   = ended_reg;
        tst_next     = tst_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;

        valid_next   = 1'b0;
        value_next   = value_reg;
        char_next    = char_reg;
        status_next  = status_reg;
        last_next    = last_reg;

        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = sym_byte[SYM_BITS-1:0];
        rd_en   = 1'b0;
        rd_addr = '0;

        c0 = first_char ? '0 : count_reg;
        o0 = first_char ? 1'b0 : ovf_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(op))
                        OP_LOAD:
                        begin
                            // Store the symbol, or drop it once the store is full
                            if (!o0)
                            begin
                                if (c0 >= CW'(MAX_SYMBOLS))
                                begin
                                    o0 = 1'b1;
                                    c0 = '0;
                                end
                                else
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = c0[AW-1:0];
                                    c0      = c0 + CW'(1);
                                end
                            end
                            count_next = c0;
                            ovf_next   = o0;
                            if (last_char)
                            begin
                                valid_next  = 1'b1;
                                value_next  = '0;
                                char_next   = '0;
                                status_next = o0 ? ST_LONG : ST_OK;
                                last_next   = 1'b1;
                            end
                        end
                        OP_NUM, OP_TEXT:
                        begin
                            text_next  = (op_t'(op) == OP_TEXT);
                            sgn_next   = want_signed;
                            start_next = bit_start;
                            len_next   = bit_count;
                            state_next = S_PREP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_PREP:
            begin
                // Fetch the first symbol while the checks settle
                rd_en     = 1'b1;
                rd_addr   = idx_first[AW-1:0];
                idx_next  = idx_first;
                off_next  = r_start;
                acc_next  = '0;
                if (!text_reg)
                begin
                    rem_next  = len_reg;
                    fill_next = sgn_reg;
                    if ((num_end > bits_total) || (len_reg == 9'd0))
                    begin
                        valid_next  = 1'b1;
                        value_next  = '0;
                        char_next   = '0;
                        status_next = (num_end > bits_total) ? ST_RANGE : ST_OK;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    left_next    = n_chars;
                    cur_end_next = EW'(start_reg) + EW'(SYM_BITS);
                    ended_next   = 1'b0;
                    tst_next     = (text_end > bits_total);
                    state_next   = (n_chars == 7'd0) ? S_IDLE : S_CHAR;
                end
            end

            S_CHAR:
            begin
                if (ended_reg || (cur_end_reg > bits_total))
                begin
                    // Text has ended or runs past the payload: emit a blank character without a fetch
                    ended_next   = 1'b1;
                    valid_next   = 1'b1;
                    value_next   = '0;
                    char_next    = '0;
                    status_next  = tst_reg ? ST_RANGE : ST_OK;
                    last_next    = (left_reg == 7'd1);
                    left_next    = left_reg - 7'd1;
                    cur_end_next = cur_end_reg + EW'(SYM_BITS);
                    state_next   = (left_reg == 7'd1) ? S_IDLE : S_CHAR;
                end
                else
                begin
                    rem_next   = 9'(SYM_BITS);
                    acc_next   = '0;
                    fill_next  = 1'b0;
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // Take the field bits from one symbol; fetch the symbol the next step needs
                acc_next  = unit_rsp.acc;
                off_next  = unit_rsp.off;
                idx_next  = idx_step;
                rem_next  = rem_step;
                fill_next = 1'b0;
                rd_en     = 1'b1;
                rd_addr   = idx_step[AW-1:0];
                if (rem_step == 9'd0)
                begin
                    valid_next = 1'b1;
                    if (!text_reg)
                    begin
                        value_next  = unit_rsp.acc;
                        char_next   = '0;
                        status_next = ST_OK;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        value_next = '0;
                        if (unit_rsp.acc[SYM_BITS-1:0] == '0)
                        begin
                            ended_next = 1'b1;
                            char_next  = '0;
                        end
                        else
                        begin
                            // Codes below 32 move up into the letters
                            char_next = {~unit_rsp.acc[SYM_BITS-1],
                                         unit_rsp.acc[SYM_BITS-1:0]};
                        end
                        status_next  = tst_reg ? ST_RANGE : ST_OK;
                        last_next    = (left_reg == 7'd1);
                        left_next    = left_reg - 7'd1;
                        cur_end_next = cur_end_reg + EW'(SYM_BITS);
                        state_next   = (left_reg == 7'd1) ? S_IDLE : S_CHAR;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        text_reg    <= text_next;
        sgn_reg     <= sgn_next;
        start_reg   <= start_next;
        len_reg     <= len_next;
        idx_reg     <= idx_next;
        off_reg     <= off_next;
        rem_reg     <= rem_next;
        acc_reg     <= acc_next;
        fill_reg    <= fill_next;
        left_reg    <= left_next;
        cur_end_reg <= cur_end_next;
        ended_reg   <= ended_next;
        tst_reg     <= tst_next;
        value_reg   <= value_next;
        char_reg    <= char_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

    assign result_valid = valid_reg;
    assign field_value  = $signed(value_reg);
    assign text_char    = char_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    // Sequencer stays one-hot
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
    else $error("sequencer state not one-hot");

    // Symbol count never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SYMBOLS))
    else $error("symbol count beyond store depth");

    // A shift step always has bits left to take, at a legal offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> ((rem_reg != 9'd0) && (off_reg < 3'd6)))
    else $error("shift step with nothing to take or bad offset");

    // A too-long status comes only from a load taken in the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (status_reg == ST_LONG)) |-> $past(accept && (op == OP_LOAD)))
    else $error("too-long status without a load request");

    // A read request always enters set-up next
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((op == OP_NUM) || (op == OP_TEXT))) |=> (state_reg == S_PREP))
    else $error("read request did not enter set-up");

endmodule

>>> rtl/ais_bf_store.sv
module ais_bf_store #(
    parameter int DEPTH = ais_bf_pkg::MAX_SYMBOLS_DEF,
    parameter int AW    = 8
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [ais_bf_pkg::SYM_BITS-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [ais_bf_pkg::SYM_BITS-1:0] rd_data
);
    import ais_bf_pkg::*;

    logic [SYM_BITS-1:0] mem [DEPTH];
    logic [SYM_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/ais_bf_unit.sv
module ais_bf_unit (
    input  ais_bf_pkg::bfu_req_t req,
    output ais_bf_pkg::bfu_rsp_t rsp
);
    import ais_bf_pkg::*;

    // Shift in the field bits that lie in one symbol, from the offset on
    always_comb
    begin
        logic [2:0]          avail;
        logic [2:0]          take;
        logic [SYM_BITS-1:0] masked;
        logic [SYM_BITS-1:0] chunk;
        logic [SYM_BITS-1:0] aligned;
        logic [VALUE_W-1:0]  base;
        logic [2:0]          off_sum;

        avail   = 3'd6 - req.off;
        take    = (req.rem < 9'(avail)) ? req.rem[2:0] : avail;
        masked  = req.sym & (6'h3F >> req.off);
        chunk   = masked >> (avail - take);
        aligned = req.sym << req.off;
        base    = (req.fill && aligned[SYM_BITS-1]) ? '1 : req.acc;
        off_sum = req.off + take;

        rsp.acc  = (base << take) | VALUE_W'(chunk);
        rsp.take = take;
        rsp.adv  = (off_sum == 3'd6);
        rsp.off  = (off_sum == 3'd6) ? 3'd0 : off_sum;
    end

endmodule

>>> tb/sv/ais_payload_bitfield_reader_checker.sv
module ais_payload_bitfield_reader_checker #(
    parameter int MAX_SYMBOLS = ais_bf_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic [1:0]                           op,
    input  logic [7:0]                           char_code,
    input  logic                                 first_char,
    input  logic                                 last_char,
    input  logic [10:0]                          bit_start,
    input  logic [8:0]                           bit_count,
    input  logic                                 want_signed,
    input  logic                                 result_valid,
    input  logic signed [ais_bf_pkg::VALUE_W-1:0] field_value,
    input  logic [6:0]                           text_char,
    input  logic [1:0]                           status,
    input  logic                                 last,
    output int                                   fail_count,
    output int                                   due_count
);
    import ais_bf_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [6:0]         ch;
        status_t            st;
        logic               fin;
    } decoded_t;

    logic [SYM_BITS-1:0] held_syms [MAX_SYMBOLS];
    int                  held_count;
    logic                held_overflow;
    decoded_t            decoded_due [$];
    int                  errors_seen;

    // Gather len bits MSB-first from bit position from; 0 when past the payload end
    function automatic logic extract_bits(input int from, input int len, input logic sgn,
                                          output logic [VALUE_W-1:0] val);
        logic [VALUE_W-1:0] acc;
        logic               b;
        int                 pos;
        int                 i;
        acc = '0;
        val = '0;
        if (from + len > held_count * SYM_BITS)
            return 1'b0;
        for (i = 0; i < len; i++)
        begin
            pos = from + i;
            b   = held_syms[pos / SYM_BITS][SYM_BITS - 1 - pos % SYM_BITS];
            acc = acc << 1;
            if (i == 0 && sgn && b)
                acc = ~acc;
            acc = acc | VALUE_W'(b);
        end
        val = acc;
        return 1'b1;
    endfunction

    function automatic void queue_result(input logic [VALUE_W-1:0] value, input logic [6:0] ch,
                                         input status_t st, input logic fin);
        decoded_t r;
        r.value = value;
        r.ch    = ch;
        r.st    = st;
        r.fin   = fin;
        decoded_due.push_back(r);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        int                 v;
        int                 n;
        int                 k;
        logic [VALUE_W-1:0] word;
        logic               ok;
        logic               ended;
        status_t            st;
        logic [6:0]         ch;
        decoded_t           head;
        if (!rst_n)
        begin
            held_count    = 0;
            held_overflow = 1'b0;
            errors_seen   = 0;
            decoded_due.delete();
        end
        else
        begin
            // a result at this edge always belongs to an earlier request: check it first
            if (result_valid)
            begin
                if (decoded_due.size() == 0)
                begin
                    $error("unrequested result: field_value %h text_char %h status %0d last %b",
                           field_value, text_char, status, last);
                    errors_seen++;
                end
                else
                begin
                    head = decoded_due.pop_front();
                    if (field_value !== head.value)
                    begin
                        $error("field_value: expected %h, actual %h", head.value, field_value);
                        errors_seen++;
                    end
                    if (text_char !== head.ch)
                    begin
                        $error("text_char: expected %h, actual %h", head.ch, text_char);
                        errors_seen++;
                    end
                    if (status !== head.st)
                    begin
                        $error("status: expected %0d, actual %0d", head.st, status);
                        errors_seen++;
                    end
                    if (last !== head.fin)
                    begin
                        $error("last: expected %b, actual %b", head.fin, last);
                        errors_seen++;
                    end
                end
            end

            if (start && !busy)
            begin
                case (op_t'(op))
                    OP_LOAD:
                    begin
                        if (first_char)
                        begin
                            held_count    = 0;
                            held_overflow = 1'b0;
                        end
                        if (!held_overflow)
                        begin
                            if (held_count >= MAX_SYMBOLS)
                            begin
                                held_overflow = 1'b1;
                                held_count    = 0;
                            end
                            else
                            begin
                                v = int'(char_code) - int'(ARMOR_BASE);
                                if (v > int'(ARMOR_LIMIT))
                                    v = v - int'(ARMOR_GAP);
                                held_syms[held_count] = v[SYM_BITS-1:0];
                                held_count++;
                            end
                        end
                        if (last_char)
                            queue_result('0, '0, held_overflow ? ST_LONG : ST_OK, 1'b1);
                    end
                    OP_NUM:
                    begin
                        ok = extract_bits(int'(bit_start), int'(bit_count), want_signed, word);
                        queue_result(word, '0, ok ? ST_OK : ST_RANGE, 1'b1);
                    end
                    OP_TEXT:
                    begin
                        n  = int'(bit_count) / SYM_BITS;
                        st = (int'(bit_start) + n * SYM_BITS > held_count * SYM_BITS) ?
                             ST_RANGE : ST_OK;
                        if (n > MAX_TEXT_CHARS)
                            n = MAX_TEXT_CHARS;
                        ended = 1'b0;
                        for (k = 0; k < n; k++)
                        begin
                            ch = '0;
                            if (!ended)
                            begin
                                ok = extract_bits(int'(bit_start) + k * SYM_BITS, SYM_BITS,
                                                  1'b0, word);
                                if (!ok || word == '0)
                                    ended = 1'b1;
                                else
                                    ch = (word < 32) ? 7'(word + 64) : 7'(word);
                            end
                            queue_result('0, ch, st, k + 1 == n);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        fail_count <= errors_seen;
        due_count  <= decoded_due.size();
    end

endmodule

>>> tb/sv/tb_ais_payload_bitfield_reader.sv
module tb_ais_payload_bitfield_reader;
    import ais_bf_pkg::*;

    localparam int RANDOM_REQUESTS = 20;
    localparam int QUIET_LIMIT     = 1000;   // well above a 511-bit read plus a sender gap
    localparam int TAIL_CYCLES     = 120;    // covers the longest numeric read
    localparam int FULL_BITS       = MAX_SYMBOLS_DEF * SYM_BITS;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               start       = 1'b0;
    logic [1:0]         op          = OP_LOAD;
    logic [7:0]         char_code   = '0;
    logic               first_char  = 1'b0;
    logic               last_char   = 1'b0;
    logic [10:0]        bit_start   = '0;
    logic [8:0]         bit_count   = '0;
    logic               want_signed = 1'b0;
    logic               busy;
    logic               result_valid;
    logic signed [31:0] field_value;
    logic [6:0]         text_char;
    logic [1:0]         status;
    logic               last;

    int   mismatch_count;
    int   results_due;
    int   quiet_cycles = 0;
    logic no_idle      = 1'b0;
    int   cur_syms     = 0;

    ais_payload_bitfield_reader u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .char_code    (char_code),
        .first_char   (first_char),
        .last_char    (last_char),
        .bit_start    (bit_start),
        .bit_count    (bit_count),
        .want_signed  (want_signed),
        .result_valid (result_valid),
        .field_value  (field_value),
        .text_char    (text_char),
        .status       (status),
        .last         (last)
    );

    ais_payload_bitfield_reader_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .char_code    (char_code),
        .first_char   (first_char),
        .last_char    (last_char),
        .bit_start    (bit_start),
        .bit_count    (bit_count),
        .want_signed  (want_signed),
        .result_valid (result_valid),
        .field_value  (field_value),
        .text_char    (text_char),
        .status       (status),
        .last         (last),
        .fail_count   (mismatch_count),
        .due_count    (results_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: abandon the run once nothing has moved on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Bias towards the armour code of symbol 0 so text terminators turn up often
    function automatic logic [7:0] random_char();
        if ($urandom_range(0, 7) == 0)
            return ARMOR_BASE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Hold the request on the ports until the block takes it. Always called just
    // after a rising edge; start stays high when the next request follows at once.
    task automatic issue_request(input op_t r_op, input logic [7:0] r_code,
                                 input logic r_first, input logic r_last,
                                 input logic [10:0] r_start, input logic [8:0] r_len,
                                 input logic r_sgn);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op          <= r_op;
        char_code   <= r_code;
        first_char  <= r_first;
        last_char   <= r_last;
        bit_start   <= r_start;
        bit_count   <= r_len;
        want_signed <= r_sgn;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Load one character; scramble the fields a load does not use
    task automatic send_load(input logic [7:0] code, input logic first, input logic fin);
        issue_request(OP_LOAD, code, first, fin, 11'($urandom_range(0, 2047)),
                      9'($urandom_range(0, 511)), 1'($urandom));
    endtask

    // Issue a field read; scramble the load-only fields
    task automatic send_read(input op_t r_op, input int from, input int len,
                             input logic sgn);
        issue_request(r_op, 8'($urandom_range(0, 255)), 1'($urandom), 1'($urandom),
                      11'(from), 9'(len), sgn);
    endtask

    // Numeric or text read, mostly inside a payload of the given bit length
    task automatic random_read(input int bits);
        op_t r_op;
        int  len;
        int  from;
        if ($urandom_range(0, 1) == 0)
        begin
            r_op = OP_NUM;
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 511) : $urandom_range(0, 32);
        end
        else
        begin
            r_op = OP_TEXT;
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(384, 511) : $urandom_range(0, 60);
        end
        if ($urandom_range(0, 4) == 0 || len >= bits)
            from = $urandom_range(0, 2047);
        else
            from = $urandom_range(0, bits - len);
        send_read(r_op, from, len, 1'($urandom));
    endtask

    // Drop start and hold off until every due result has arrived
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (results_due != 0);
    endtask

    initial
    begin : stimulus
        int   sent;
        int   k;
        int   nsym;
        int   nreads;
        logic fresh;
        logic closed;
        op_t  r_op;
        logic r_first;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: armour edges around the base, the limit and the gap
        send_load(8'd0, 1'b1, 1'b0);
        send_load(8'd255, 1'b0, 1'b0);
        send_load(8'd87, 1'b0, 1'b0);
        send_load(8'd88, 1'b0, 1'b0);
        send_load(8'd89, 1'b0, 1'b0);
        send_load(8'd119, 1'b0, 1'b1);           // closes a 36-bit payload
        send_read(OP_NUM, 0, 0, 1'b1);           // zero length
        send_read(OP_NUM, 0, 36, 1'b0);          // longer than the value word
        send_read(OP_NUM, 30, 6, 1'b1);          // ends on the last bit, negative
        send_read(OP_NUM, 31, 6, 1'b0);          // one bit past the end
        send_read(OP_NUM, 2047, 511, 1'b1);      // both fields at their top
        send_read(OP_NUM, 6, 6, 1'b1);           // signed read, positive first bit
        send_read(OP_TEXT, 0, 36, 1'b0);
        send_read(OP_TEXT, 0, 5, 1'b0);          // shorter than one symbol: no results
        send_read(OP_TEXT, 33, 12, 1'b0);        // first symbol straddles the end
        send_read(OP_TEXT, 0, 511, 1'b0);        // character count clipped to the maximum
        issue_request(OP_NONE, 8'hFF, 1'b1, 1'b1, 11'h7FF, 9'h1FF, 1'b1);
        send_load(ARMOR_BASE, 1'b1, 1'b1);       // one-symbol payload holding a terminator
        send_load(8'd65, 1'b0, 1'b1);            // append without a first flag
        send_read(OP_TEXT, 0, 12, 1'b0);         // terminator, then blanks
        send_read(OP_TEXT, 6, 6, 1'b0);
        send_read(OP_NUM, 0, 12, 1'b1);
        send_load(8'd120, 1'b1, 1'b0);           // wraps round to symbol 0
        drain_results();

        // Fill the store to capacity, read deep into it, then overflow it
        for (k = 0; k < MAX_SYMBOLS_DEF; k++)
            send_load(random_char(), k == 0, k == MAX_SYMBOLS_DEF - 1);
        repeat (8) random_read(FULL_BITS);
        send_read(OP_NUM, FULL_BITS - 32, 32, 1'b1);
        send_read(OP_TEXT, FULL_BITS - 384, 384, 1'b0);
        send_load(random_char(), 1'b0, 1'b1);    // one too many: too long
        send_load(random_char(), 1'b0, 1'b1);    // still dropped
        send_read(OP_NUM, 0, 1, 1'b0);           // payload now empty
        send_read(OP_NUM, 0, 0, 1'b0);
        drain_results();
        cur_syms = 0;

        // Random: mostly short payloads followed by reads, the rest noise
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7)
            begin
                nsym   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14)
                                                     : $urandom_range(1, 8);
                fresh  = ($urandom_range(0, 7) != 0);
                closed = ($urandom_range(0, 7) != 0);
                if (fresh)
                    cur_syms = 0;
                for (k = 0; k < nsym; k++)
                    send_load(random_char(), fresh && k == 0, closed && k == nsym - 1);
                cur_syms = cur_syms + nsym;
                if (cur_syms > MAX_SYMBOLS_DEF)
                    cur_syms = MAX_SYMBOLS_DEF;
                sent   = sent + nsym;
                nreads = $urandom_range(1, 6);
                repeat (nreads) random_read(cur_syms * SYM_BITS);
                sent = sent + nreads;
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    r_op    = op_t'($urandom_range(0, 3));
                    r_first = 1'($urandom);
                    issue_request(r_op, random_char(), r_first, 1'($urandom),
                                  11'($urandom_range(0, 2047)), 9'($urandom_range(0, 511)),
                                  1'($urandom));
                    if (r_op != OP_NONE)
                        sent++;
                    if (r_op == OP_LOAD)
                        cur_syms = r_first ? 1 : cur_syms + 1;
                end
            end
            if ($urandom_range(0, 11) == 0)
                drain_results();
        end

        // Let every due result arrive, then allow for a read still in flight
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> ais_payload_bitfield_reader.f
rtl/ais_bf_pkg.sv
rtl/ais_bf_store.sv
rtl/ais_bf_unit.sv
rtl/ais_payload_bitfield_reader.sv
tb/sv/ais_payload_bitfield_reader_checker.sv
tb/sv/tb_ais_payload_bitfield_reader.sv
